[src/fbfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_pkg
// Types and constants shared by the fixed block free-list allocator.
// ----------------------------------------------------------------------------
package fbfa_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LINK_W     = IDX_W + 1;
  localparam int BW_W       = 8;
  localparam int PB_W       = 11;
  localparam int ADDR_W     = 18;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic {
    REG_BLOCK_WORDS = 1'b0,
    REG_POOL_BLOCKS = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic [BW_W-1:0] block_words;
    logic [PB_W-1:0] pool_blocks;
  } cfg_t;

endpackage

[src/fbfa_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_req_if
// Request channel: action and the block index of a free.
// ----------------------------------------------------------------------------
interface fbfa_req_if;
  logic                         valid;
  logic                         ready;
  fbfa_pkg::action_t            action;
  logic [fbfa_pkg::IDX_W-1:0]   block_index;

  modport source (output valid, action, block_index, input ready);
  modport sink   (input valid, action, block_index, output ready);
endinterface

[src/fbfa_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_rsp_if
// Result channel: one item for each allocate request.
// ----------------------------------------------------------------------------
interface fbfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [fbfa_pkg::IDX_W-1:0]   given_index;
  logic [fbfa_pkg::ADDR_W-1:0]  given_address;

  modport source (output valid, granted, given_index, given_address, input ready);
  modport sink   (input valid, granted, given_index, given_address, output ready);
endinterface

[src/fixed_block_free_list_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Hands out equal-sized blocks from a LIFO free list or from freshly opened
// pools, takes freed blocks back and forgets everything on release.
//
//   Channel  Role        Carries
//   req      sink        action, block_index
//   rsp      source      granted, given_index, given_address
//   APB      slave       block_words (0x0), pool_blocks (0x4)
//
// A free, a release or an allocation served from a pool is handled in ST_IDLE.
// An allocation from the free list goes on through ST_POP, as the head's link
// comes out of the registered read port of the link memory.
// Reset clears the list and the pools at once; link memory needs no sweep.
// A result waits in the output register; a new request is taken in ST_IDLE
// while the register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit (
  input  logic                           clk,
  input  logic                           rst,
  fbfa_req_if.sink                       req,
  fbfa_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [fbfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [fbfa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  fbfa_pkg::cfg_t cfg;

  fbfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbfa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.granted |-> rsp.given_index == '0 && rsp.given_address == '0)
    else $error("failed allocation carries a nonzero block");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while result is stalled");

  a_alloc_result: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.action == fbfa_pkg::ACT_ALLOC
      |=> rsp.valid || !req.ready)
    else $error("allocation produced neither a result nor a pop cycle");

endmodule

[src/fbfa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fbfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/fbfa_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_cfg
// APB register file holding block_words and pool_blocks.
// ----------------------------------------------------------------------------
module fbfa_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [fbfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [fbfa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output fbfa_pkg::cfg_t                 cfg
);

  fbfa_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = fbfa_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_words <= fbfa_pkg::BW_W'(1);
      cfg.pool_blocks <= fbfa_pkg::PB_W'(16);
    end else if (wr_en) begin
      unique case (reg_sel)
        fbfa_pkg::REG_BLOCK_WORDS: cfg.block_words <= pwdata[fbfa_pkg::BW_W-1:0];
        fbfa_pkg::REG_POOL_BLOCKS: cfg.pool_blocks <= pwdata[fbfa_pkg::PB_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fbfa_pkg::REG_BLOCK_WORDS:
        prdata = fbfa_pkg::PDATA_W'(cfg.block_words);
      fbfa_pkg::REG_POOL_BLOCKS:
        prdata = fbfa_pkg::PDATA_W'(cfg.pool_blocks);
    endcase
  end

endmodule

[src/fbfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_ctrl
// Free-list head, pool counters, link memory and the result register.
// ----------------------------------------------------------------------------
module fbfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  fbfa_pkg::cfg_t       cfg,
  fbfa_req_if.sink             req,
  fbfa_rsp_if.source           rsp
);

  fbfa_pkg::state_t             state, state_next;
  logic [fbfa_pkg::IDX_W-1:0]   free_head, free_head_next;
  logic                         free_nonempty, free_nonempty_next;
  logic [fbfa_pkg::CNT_W-1:0]   carved_count, carved_count_next;
  logic [fbfa_pkg::CNT_W-1:0]   pool_end, pool_end_next;
  logic [fbfa_pkg::CNT_W-1:0]   room;

  logic                         link_we;
  logic [fbfa_pkg::LINK_W-1:0]  link_wdata;
  logic [fbfa_pkg::LINK_W-1:0]  link_rdata;

  logic                         accept;
  logic                         out_load;
  logic                         out_granted;
  logic [fbfa_pkg::IDX_W-1:0]   out_index;
  logic                         out_free;

  // Each link entry holds the next block and a bit telling that one follows.
  fbfa_ram #(
    .WIDTH (fbfa_pkg::LINK_W),
    .DEPTH (fbfa_pkg::NUM_BLOCKS)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (req.block_index),
    .wdata (link_wdata),
    .raddr (free_head),
    .rdata (link_rdata)
  );

  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == fbfa_pkg::ST_IDLE) && out_free;
  assign accept     = req.valid && req.ready;
  assign link_wdata = {free_nonempty, free_head};
  assign room       = fbfa_pkg::CNT_W'(fbfa_pkg::NUM_BLOCKS) - carved_count;

  always_comb begin
    state_next         = state;
    free_head_next     = free_head;
    free_nonempty_next = free_nonempty;
    carved_count_next  = carved_count;
    pool_end_next      = pool_end;
    link_we            = 1'b0;
    out_load           = 1'b0;
    out_granted        = 1'b0;
    out_index          = '0;

    unique case (state)
      fbfa_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.action)
            fbfa_pkg::ACT_FREE: begin
              link_we            = 1'b1;
              free_head_next     = req.block_index;
              free_nonempty_next = 1'b1;
            end
            fbfa_pkg::ACT_RELEASE: begin
              free_head_next     = '0;
              free_nonempty_next = 1'b0;
              carved_count_next  = '0;
              pool_end_next      = '0;
            end
            fbfa_pkg::ACT_ALLOC: begin
              // The link of the head is read now and consumed next cycle.
              if (free_nonempty) begin
                state_next = fbfa_pkg::ST_POP;
              end else if (carved_count < pool_end) begin
                out_load          = 1'b1;
                out_granted       = 1'b1;
                out_index         = carved_count[fbfa_pkg::IDX_W-1:0];
                carved_count_next = carved_count + fbfa_pkg::CNT_W'(1);
              end else if (cfg.pool_blocks != '0 && room >= cfg.pool_blocks) begin
                out_load          = 1'b1;
                out_granted       = 1'b1;
                out_index         = carved_count[fbfa_pkg::IDX_W-1:0];
                carved_count_next = carved_count + fbfa_pkg::CNT_W'(1);
                pool_end_next     = carved_count + cfg.pool_blocks;
              end else begin
                out_load = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      fbfa_pkg::ST_POP: begin
        out_load           = 1'b1;
        out_granted        = 1'b1;
        out_index          = free_head;
        free_head_next     = link_rdata[fbfa_pkg::IDX_W-1:0];
        free_nonempty_next = link_rdata[fbfa_pkg::IDX_W];
        state_next         = fbfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fbfa_pkg::ST_IDLE;
      free_head     <= '0;
      free_nonempty <= 1'b0;
      carved_count  <= '0;
      pool_end      <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      state         <= state_next;
      free_head     <= free_head_next;
      free_nonempty <= free_nonempty_next;
      carved_count  <= carved_count_next;
      pool_end      <= pool_end_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.granted       <= out_granted;
      rsp.given_index   <= out_index;
      rsp.given_address <= fbfa_pkg::ADDR_W'(out_index) *
                           fbfa_pkg::ADDR_W'(cfg.block_words);
    end
  end

endmodule

[tb/fbfa_grant_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_grant_checker
// Watches the request, result and register ports of the block allocator,
// keeps its own copy of the free list and pool state, and compares every
// result with the grant it predicts for the oldest open allocate request.
// ----------------------------------------------------------------------------
module fbfa_grant_checker import fbfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fbfa_req_if                req,
  fbfa_rsp_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 failures,
  output int                 pending
);

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] address;
  } grant_t;

  grant_t grant_queue[$];
  grant_t want;

  logic [IDX_W-1:0] next_link [NUM_BLOCKS];
  logic             more_link [NUM_BLOCKS];
  logic [IDX_W-1:0] list_head;
  logic             list_valid;
  logic [CNT_W-1:0] carved;
  logic [CNT_W-1:0] pool_limit;
  logic [BW_W-1:0]  words;
  logic [PB_W-1:0]  pool_len;
  logic [PDATA_W-1:0] reg_value;

  function automatic void forget_blocks();
    list_head  = '0;
    list_valid = 1'b0;
    carved     = '0;
    pool_limit = '0;
  endfunction

  // Pops the list first, then carves from the open pool, then tries to open
  // a new pool that must fit whole into what is left of the store.
  function automatic grant_t grant_block();
    grant_t           g;
    logic [IDX_W-1:0] got;
    logic             ok;
    got = '0;
    ok  = 1'b0;
    if (list_valid) begin
      got        = list_head;
      list_head  = next_link[got];
      list_valid = more_link[got];
      ok         = 1'b1;
    end else if (carved < pool_limit) begin
      got    = carved[IDX_W-1:0];
      carved = carved + CNT_W'(1);
      ok     = 1'b1;
    end else if (pool_len != 0 && (NUM_BLOCKS - int'(carved)) >= int'(pool_len)) begin
      pool_limit = carved + CNT_W'(pool_len);
      got        = carved[IDX_W-1:0];
      carved     = carved + CNT_W'(1);
      ok         = 1'b1;
    end
    g.granted = ok;
    g.index   = ok ? got : '0;
    g.address = ok ? ADDR_W'(int'(got) * int'(words)) : '0;
    return g;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      forget_blocks();
      words     = BW_W'(1);
      pool_len  = PB_W'(16);
      grant_queue.delete();
      failures  = 0;
    end else begin
      if (psel && penable && pready && paddr[1:0] == 2'b00) begin
        reg_value = (reg_idx_t'(paddr[2]) == REG_BLOCK_WORDS) ? PDATA_W'(words)
                                                               : PDATA_W'(pool_len);
        if (pwrite) begin
          case (reg_idx_t'(paddr[2]))
            REG_BLOCK_WORDS: words    = pwdata[BW_W-1:0];
            REG_POOL_BLOCKS: pool_len = pwdata[PB_W-1:0];
          endcase
        end else if (prdata !== reg_value) begin
          $error("prdata at 0x%0h: expected %0d, got %0d", paddr, reg_value, prdata);
          failures++;
        end
      end

      if (req.valid && req.ready) begin
        case (req.action)
          ACT_ALLOC: grant_queue.push_back(grant_block());
          ACT_FREE: begin
            next_link[req.block_index] = list_head;
            more_link[req.block_index] = list_valid;
            list_head  = req.block_index;
            list_valid = 1'b1;
          end
          ACT_RELEASE: forget_blocks();
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready) begin
        if (grant_queue.size() == 0) begin
          $error("result with no allocate request open: granted %0d index %0d address %0d",
                 rsp.granted, rsp.given_index, rsp.given_address);
          failures++;
        end else begin
          want = grant_queue.pop_front();
          if (rsp.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, rsp.granted);
            failures++;
          end
          if (rsp.given_index !== want.index) begin
            $error("given_index: expected %0d, got %0d", want.index, rsp.given_index);
            failures++;
          end
          if (rsp.given_address !== want.address) begin
            $error("given_address: expected %0d, got %0d", want.address, rsp.given_address);
            failures++;
          end
        end
      end
    end
    pending = grant_queue.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the block allocator with directed allocate, free and release
// requests, then with random phases under changing block and pool sizes,
// while the receiver stalls at random until the final phase; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import fbfa_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 failures;
  int                 pending;
  bit                 calm = 1'b0;

  fbfa_req_if req ();
  fbfa_rsp_if rsp ();

  fixed_block_free_list_allocator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fbfa_grant_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .failures (failures),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result receiver: random stall bursts until the final phase.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Leaves psel high; the caller either starts another access or rests the bus.
  task automatic apb_access(reg_idx_t r, logic write, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic configure(logic [BW_W-1:0] bw, logic [PB_W-1:0] pb);
    apb_access(REG_BLOCK_WORDS, 1'b1, PDATA_W'(bw));
    apb_access(REG_POOL_BLOCKS, 1'b1, PDATA_W'(pb));
    apb_access(REG_BLOCK_WORDS, 1'b0, '0);
    apb_access(REG_POOL_BLOCKS, 1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds the request until it is taken, then maybe idles for a burst.
  task automatic send(action_t a, logic [IDX_W-1:0] idx);
    req.valid       <= 1'b1;
    req.action      <= a;
    req.block_index <= idx;
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    if (!calm && $urandom_range(0, 6) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Frees give no result, so settle waits on after the grants are in as well.
  task automatic settle();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 52)
      send(ACT_ALLOC, IDX_W'($urandom));
    else if (pick < 92)
      send(ACT_FREE, ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                                                 : IDX_W'($urandom_range(0, 47)));
    else if (pick < 96)
      send(ACT_RELEASE, IDX_W'($urandom));
    else
      send(action_t'(2'd3), IDX_W'($urandom));
  endtask

  initial begin
    logic [BW_W-1:0] bw;
    logic [PB_W-1:0] pb;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.action      <= ACT_ALLOC;
    req.block_index <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Largest blocks and pools: double free, highest index and address.
    configure(8'd255, 11'd1024);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '1);
    send(ACT_FREE, 10'd1023);
    send(ACT_FREE, 10'd1023);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(action_t'(2'd3), '1);
    send(ACT_FREE, 10'h2AA);
    send(ACT_FREE, 10'h155);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(ACT_RELEASE, '1);
    send(ACT_ALLOC, '0);
    settle();

    // Zero-sized pools can never open; zero-word blocks sit at address zero.
    configure(8'd0, 11'd0);
    send(ACT_ALLOC, '0);
    send(ACT_FREE, 10'd5);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(ACT_RELEASE, '0);
    settle();

    // Single-block pools, then a pool too large for the rest of the store.
    configure(8'd3, 11'd1);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    settle();
    configure(8'd3, 11'd1024);
    send(ACT_ALLOC, '0);
    send(ACT_FREE, 10'd1);
    send(ACT_ALLOC, '0);
    settle();

    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 5))
        0:       bw = 8'd0;
        1:       bw = 8'd255;
        2:       bw = 8'd1;
        default: bw = BW_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 9))
        0:       pb = 11'd0;
        1:       pb = 11'd1024;
        2:       pb = 11'd2047;
        3:       pb = 11'd1;
        default: pb = PB_W'($urandom_range(2, 48));
      endcase
      if (phase == 6)
        calm = 1'b1;
      configure(bw, pb);
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 40)
          settle();
        random_request();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
